// File: rtl/rltd_pkg.sv
// shared constants and types for the run-length token decoder
package rltd_pkg;

	localparam int unsigned RLTD_MAX_DIGITS  = 32;
	localparam int unsigned RLTD_COUNT_WIDTH = 32;
	localparam int unsigned RLTD_LEN_WIDTH   = 32;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef logic [7:0] byte_t;
	typedef logic [RLTD_LEN_WIDTH-1:0] len_t;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	function automatic logic is_space(input byte_t b);
		is_space = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic logic is_digit(input byte_t b);
		is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

endpackage

// File: rtl/rltd_if.sv
// valid/ready channels for compressed bytes and decoded runs
interface rltd_byte_if;
	logic            valid;
	logic            ready;
	rltd_pkg::byte_t in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface rltd_run_if;
	logic            valid;
	logic            ready;
	rltd_pkg::byte_t out_byte;
	rltd_pkg::len_t  run_length;

	modport source (output valid, output out_byte, output run_length, input ready);
	modport sink (input valid, input out_byte, input run_length, output ready);
endinterface

// File: rtl/run_length_token_decoder_core.sv
// run-length token decoder: compressed byte beats in, run beats out
// Takes one compressed byte per cycle unless a run waits on a busy output register, and
// gives at most one run per byte. A byte is latched into an input stage at acceptance and
// decoded there combinationally against the token state; its run is then registered in
// the output register and offered. The token state (delimiter, kept count, parse phase,
// sign, saturating magnitude) is updated in that same cycle, which sets the rate at one
// byte per clock. A byte that gives no run passes through even while a run waits to be
// taken; a byte that gives a run waits in the input stage until the output register
// frees. Literals come out with length 1, tokens opened by '+' or '-' come out as '1' or '0'
// runs at their closing delimiter, zero-length tokens give nothing, and an open token at the
// end of the stream gives nothing.
module run_length_token_decoder_core #(
	parameter int unsigned MAX_DIGITS  = rltd_pkg::RLTD_MAX_DIGITS,
	parameter int unsigned COUNT_WIDTH = rltd_pkg::RLTD_COUNT_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	rltd_byte_if.sink stream,
	rltd_run_if.source runs
);
	import rltd_pkg::*;

	localparam int unsigned KW = $clog2(MAX_DIGITS + 1);
	localparam int unsigned EW = COUNT_WIDTH + 4;
	localparam int unsigned LW = (COUNT_WIDTH > RLTD_LEN_WIDTH) ? COUNT_WIDTH : RLTD_LEN_WIDTH;

	// input stage
	logic  valid_s1;
	byte_t byte_s1;

	// token state
	logic                   in_token_q;
	logic                   plus_q;
	logic [KW-1:0]          kept_q;
	phase_t                 phase_q;
	logic                   neg_q;
	logic [COUNT_WIDTH-1:0] value_q;

	// result register
	logic  res_valid_q;
	byte_t out_byte_q;
	len_t  run_length_q;

	logic                   emit;
	byte_t                  emit_byte;
	len_t                   emit_len;
	logic                   advance;
	logic                   out_free;
	logic                   in_token_d;
	logic                   plus_d;
	logic [KW-1:0]          kept_d;
	phase_t                 phase_d;
	logic                   neg_d;
	logic [COUNT_WIDTH-1:0] value_d;
	logic                   is_delim;
	logic                   is_closer;
	logic [3:0]             digit;
	logic [EW-1:0]          prod;
	logic [COUNT_WIDTH-1:0] acc;
	logic [LW-1:0]          len_wide;

	assign out_free     = !res_valid_q || runs.ready;
	assign advance      = valid_s1 && (!emit || out_free);
	assign stream.ready = !valid_s1 || advance;

	assign is_delim  = (byte_s1 == CH_PLUS) || (byte_s1 == CH_MINUS);
	assign is_closer = byte_s1 == (plus_q ? CH_PLUS : CH_MINUS);
	assign digit     = 4'(byte_s1 - CH_ZERO);

	// magnitude times ten plus digit, saturating
	assign prod = (EW'(value_q) << 3) + (EW'(value_q) << 1) + EW'(digit);
	assign acc  = (prod > EW'({COUNT_WIDTH{1'b1}})) ? {COUNT_WIDTH{1'b1}} :
		prod[COUNT_WIDTH-1:0];

	assign len_wide = neg_q ? '0 : LW'(value_q);

	always_comb begin
		in_token_d = in_token_q;
		plus_d     = plus_q;
		kept_d     = kept_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		value_d    = value_q;
		emit       = 1'b0;
		emit_byte  = byte_s1;
		emit_len   = len_t'(1);
		if (!in_token_q) begin
			if (is_delim) begin
				in_token_d = 1'b1;
				plus_d     = byte_s1 == CH_PLUS;
				kept_d     = '0;
				phase_d    = PH_SKIP;
				neg_d      = 1'b0;
				value_d    = '0;
			end else begin
				emit = 1'b1;
			end
		end else if (is_closer) begin
			in_token_d = 1'b0;
			plus_d     = 1'b0;
			kept_d     = '0;
			phase_d    = PH_SKIP;
			neg_d      = 1'b0;
			value_d    = '0;
			emit_byte  = plus_q ? CH_ONE : CH_ZERO;
			emit_len   = (len_wide > LW'({RLTD_LEN_WIDTH{1'b1}})) ? '1 :
				len_wide[RLTD_LEN_WIDTH-1:0];
			emit       = len_wide != '0;
		end else if (kept_q < KW'(MAX_DIGITS)) begin
			kept_d = kept_q + 1'b1;
			unique case (phase_q)
				PH_SKIP: begin
					if (is_space(byte_s1)) begin
						phase_d = PH_SKIP;
					end else if (is_delim) begin
						neg_d   = byte_s1 == CH_MINUS;
						phase_d = PH_DIGITS;
					end else if (is_digit(byte_s1)) begin
						value_d = acc;
						phase_d = PH_DIGITS;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_DIGITS: begin
					if (is_digit(byte_s1)) begin
						value_d = acc;
					end else begin
						phase_d = PH_DONE;
					end
				end
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				default: begin
					phase_d = PH_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q <= 1'b0;
			plus_q     <= 1'b0;
			kept_q     <= '0;
			phase_q    <= PH_SKIP;
			neg_q      <= 1'b0;
			value_q    <= '0;
		end else if (advance) begin
			in_token_q <= in_token_d;
			plus_q     <= plus_d;
			kept_q     <= kept_d;
			phase_q    <= phase_d;
			neg_q      <= neg_d;
			value_q    <= value_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (runs.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_byte_q   <= emit_byte;
			run_length_q <= emit_len;
		end
	end

	assign runs.valid      = res_valid_q;
	assign runs.out_byte   = out_byte_q;
	assign runs.run_length = run_length_q;

	a_kept_limit: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= KW'(MAX_DIGITS))
		else $error("kept count past limit");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_token_q |-> (kept_q == '0 && value_q == '0 && !neg_q && phase_q == PH_SKIP))
		else $error("token state not cleared outside a token");

	a_no_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		runs.valid |-> runs.run_length != '0)
		else $error("run of length zero offered");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(stream.valid && stream.ready) |=> valid_s1)
		else $error("accepted beat not held in input stage");

	a_stall_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> ($stable(value_q) && $stable(kept_q) && valid_s1))
		else $error("token state moved while input stage stalled");

endmodule

// File: test/rltd_run_checker.sv
// checker for the run-length token decoder: predicts runs from byte beats and compares
`timescale 1ns / 1ps

module rltd_run_checker (
	input  logic  clk,
	input  logic  arst_n,
	rltd_byte_if  stream,
	rltd_run_if   runs,
	output int    errors,
	output int    pending
);
	import rltd_pkg::*;

	localparam logic [63:0] MAG_CAP = {64{1'b1}} >> (64 - RLTD_COUNT_WIDTH);
	localparam logic [63:0] LEN_CAP = {64{1'b1}} >> (64 - RLTD_LEN_WIDTH);

	typedef struct packed {
		byte_t sym;
		len_t  len;
	} run_t;

	run_t expected_runs[$];
	int   fail_total;

	logic        tok_open;
	logic        tok_plus;
	logic [5:0]  tok_kept;
	phase_t      tok_phase;
	logic        tok_neg;
	logic [63:0] tok_mag;

	run_t got;
	run_t want;

	function automatic logic [63:0] add_digit(input logic [63:0] mag, input logic [3:0] d);
		if (mag > (MAG_CAP - 64'(d)) / 64'd10)
			return MAG_CAP;
		return mag * 64'd10 + 64'(d);
	endfunction

	task automatic clear_token();
		tok_open  = 1'b0;
		tok_plus  = 1'b0;
		tok_kept  = '0;
		tok_phase = PH_SKIP;
		tok_neg   = 1'b0;
		tok_mag   = '0;
	endtask

	task automatic decode_byte(input byte_t b);
		logic [63:0] len;
		logic        is_dig;
		logic        is_ws;
		run_t        r;
		is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
		is_ws  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
		if (!tok_open) begin
			if (b == CH_PLUS || b == CH_MINUS) begin
				clear_token();
				tok_open = 1'b1;
				tok_plus = (b == CH_PLUS);
			end else begin
				r.sym = b;
				r.len = len_t'(1);
				expected_runs.push_back(r);
			end
		end else if (b == (tok_plus ? CH_PLUS : CH_MINUS)) begin
			len = tok_neg ? 64'd0 : tok_mag;
			if (len > LEN_CAP)
				len = LEN_CAP;
			if (len != 64'd0) begin
				r.sym = tok_plus ? CH_ONE : CH_ZERO;
				r.len = len_t'(len);
				expected_runs.push_back(r);
			end
			clear_token();
		end else if (tok_kept < RLTD_MAX_DIGITS) begin
			tok_kept++;
			case (tok_phase)
				PH_SKIP: begin
					if (!is_ws) begin
						if (b == CH_PLUS || b == CH_MINUS) begin
							tok_neg   = (b == CH_MINUS);
							tok_phase = PH_DIGITS;
						end else if (is_dig) begin
							tok_mag   = add_digit(tok_mag, 4'(b - CH_ZERO));
							tok_phase = PH_DIGITS;
						end else begin
							tok_phase = PH_DONE;
						end
					end
				end
				PH_DIGITS: begin
					if (is_dig)
						tok_mag = add_digit(tok_mag, 4'(b - CH_ZERO));
					else
						tok_phase = PH_DONE;
				end
				default: begin
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_token();
			expected_runs.delete();
			fail_total = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			// outputs first, so a run cannot be matched by the beat of this same edge
			if (runs.valid && runs.ready) begin
				got.sym = runs.out_byte;
				got.len = runs.run_length;
				if (expected_runs.size() == 0) begin
					if (fail_total < 10)
						$display("unexpected run: out_byte %h run_length %0d", got.sym, got.len);
					fail_total++;
				end else begin
					want = expected_runs.pop_front();
					if (got.sym !== want.sym || got.len !== want.len) begin
						if (fail_total < 10)
							$display("mismatch: expected out_byte %h run_length %0d, got %h %0d",
								want.sym, want.len, got.sym, got.len);
						fail_total++;
					end
				end
			end
			if (stream.valid && stream.ready)
				decode_byte(stream.in_byte);
			pending <= expected_runs.size();
			errors  <= fail_total;
		end
	end

endmodule

// File: test/tb_top.sv
// testbench top for the run-length token decoder: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_top;
	import rltd_pkg::*;

	localparam int ITEM_TOTAL  = 1050;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 20;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   sent;
	int   cycle;
	int   quiet_cycles;
	bit   timed_out;
	bit   paused;

	byte_t b;
	byte_t opener;
	byte_t other;
	int    kind;
	int    n;
	int    i;

	byte_t directed_bytes[] = '{
		8'h00, 8'hFF,
		CH_PLUS, 8'h35, CH_PLUS,
		CH_PLUS, 8'h09, CH_MINUS, 8'h33, CH_PLUS,
		CH_MINUS, CH_PLUS, 8'h37, CH_MINUS,
		CH_PLUS, 8'h30, CH_PLUS,
		CH_PLUS, 8'h31, 8'h00, 8'h32, CH_PLUS,
		CH_MINUS, 8'h0D, 8'h20, 8'h34, 8'h32, CH_MINUS
	};

	rltd_byte_if byte_ch();
	rltd_run_if  run_ch();

	run_length_token_decoder_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (byte_ch),
		.runs   (run_ch)
	);

	rltd_run_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (byte_ch),
		.runs    (run_ch),
		.errors  (errors),
		.pending (pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		run_ch.ready <= (cycle >= 600 && cycle < 1000) || ($urandom_range(99) >= 31);
	end

	task automatic send_byte(input byte_t val);
		while ((sent < 300 || sent >= 500) && $urandom_range(99) < 31) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.in_byte <= val;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	initial begin
		arst_n          <= 1'b0;
		byte_ch.valid   <= 1'b0;
		byte_ch.in_byte <= '0;
		sent         = 0;
		quiet_cycles = 0;
		timed_out    = 1'b0;
		paused       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			begin
				for (i = 0; i < directed_bytes.size(); i++)
					send_byte(directed_bytes[i]);

				while (sent < ITEM_TOTAL) begin
					if (!paused && sent >= 700) begin
						// hold the stream until every run owed so far is out
						paused = 1'b1;
						byte_ch.valid <= 1'b0;
						@(posedge clk);
						while (pending != 0)
							@(posedge clk);
					end
					kind   = $urandom_range(99);
					opener = $urandom_range(1) ? CH_PLUS : CH_MINUS;
					other  = (opener == CH_PLUS) ? CH_MINUS : CH_PLUS;
					if (kind < 25) begin
						send_byte(byte_t'($urandom_range(255)));
					end else if (kind < 80) begin
						// well-formed token with random content
						send_byte(opener);
						n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
						repeat (n)
							send_byte(($urandom_range(5) == 0) ? CH_SPACE
								: byte_t'(CH_TAB + $urandom_range(4)));
						if ($urandom_range(9) < 2)
							send_byte(other);
						n = $urandom_range(19);
						if (n < 2)
							n = 0;
						else if (n < 14)
							n = $urandom_range(1, 4);
						else if (n < 19)
							n = $urandom_range(5, 12);
						else
							n = $urandom_range(13, 20);
						repeat (n)
							send_byte(byte_t'(CH_ZERO + $urandom_range(9)));
						if ($urandom_range(7) == 0) begin
							send_byte($urandom_range(1) ? 8'h00 : byte_t'(8'h41 + $urandom_range(25)));
							send_byte(byte_t'(CH_ZERO + $urandom_range(9)));
						end
						send_byte(opener);
					end else if (kind < 92) begin
						send_byte(opener);
						n = $urandom_range(8);
						repeat (n) begin
							do
								b = byte_t'($urandom_range(255));
							while (b == opener);
							send_byte(b);
						end
						send_byte(opener);
					end else begin
						// long token that may run past the keep limit
						send_byte(opener);
						repeat ($urandom_range(26, 31))
							send_byte(CH_ZERO);
						repeat ($urandom_range(2, 9))
							send_byte(byte_t'(CH_ZERO + $urandom_range(9)));
						send_byte(opener);
					end
				end

				byte_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
				repeat (DRAIN_WAIT) @(posedge clk);
			end
			begin
				while (quiet_cycles < QUIET_LIMIT) begin
					@(posedge clk);
					if ((byte_ch.valid && byte_ch.ready) || (run_ch.valid && run_ch.ready))
						quiet_cycles = 0;
					else
						quiet_cycles++;
				end
				timed_out = 1'b1;
			end
		join_any

		if (!timed_out && errors == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
